@@ src/dmap_pkg.sv @@
// ----------------------------------------------------------------------------
// dmap_pkg
// Shared constants and types of the dual moving-average pressure filter.
// ----------------------------------------------------------------------------
package dmap_pkg;

   localparam int unsigned DMAP_WINDOW_DEPTH = 8;
   localparam int unsigned ADC_W             = 12;
   localparam int unsigned FS_W              = 16;
   localparam int unsigned FRAC_W            = 8;
   localparam int unsigned PSI_W             = 24;
   localparam int unsigned DIV_STEPS         = PSI_W;

   localparam logic [FS_W-1:0] FS_RESET = 16'd5000;

   typedef struct packed {
      logic busy;
      logic done;
   } dmap_div_stat_type;

endpackage

@@ src/dmap_if.sv @@
// ----------------------------------------------------------------------------
// dmap channel interfaces
// Sample, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmap_req_if;
   import dmap_pkg::*;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_a;
   logic [ADC_W-1:0] adc_b;
   modport source (output valid, adc_a, adc_b, input ready);
   modport sink   (input valid, adc_a, adc_b, output ready);
endinterface

interface dmap_rsp_if;
   import dmap_pkg::*;
   logic             valid;
   logic             ready;
   logic [PSI_W-1:0] psi_a;
   logic [PSI_W-1:0] psi_b;
   modport source (output valid, psi_a, psi_b, input ready);
   modport sink   (input valid, psi_a, psi_b, output ready);
endinterface

interface dmap_csr_if;
   import dmap_pkg::*;
   logic            valid;
   logic            ready;
   logic [FS_W-1:0] full_scale_psi;
   modport source (output valid, full_scale_psi, input ready);
   modport sink   (input valid, full_scale_psi, output ready);
endinterface

@@ src/dmap_window.sv @@
// ----------------------------------------------------------------------------
// dmap_window
// Two sample windows, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dmap_window #(
   parameter int unsigned DEPTH = dmap_pkg::DMAP_WINDOW_DEPTH,
   parameter int unsigned PTR_W = 3
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [PTR_W-1:0]          wr_addr,
   input  logic [dmap_pkg::ADC_W-1:0] wr_a,
   input  logic [dmap_pkg::ADC_W-1:0] wr_b,
   input  logic [PTR_W-1:0]          rd_addr,
   output logic [dmap_pkg::ADC_W-1:0] rd_a,
   output logic [dmap_pkg::ADC_W-1:0] rd_b
);
   import dmap_pkg::*;

   logic [ADC_W-1:0] mem_a [DEPTH];
   logic [ADC_W-1:0] mem_b [DEPTH];
   logic [ADC_W-1:0] rd_a_ff;
   logic [ADC_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_a;
         mem_b[wr_addr] <= wr_b;
      end
      rd_a_ff <= mem_a[rd_addr];
      rd_b_ff <= mem_b[rd_addr];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

@@ src/dmap_div.sv @@
// ----------------------------------------------------------------------------
// dmap_div
// Shared scaling unit: one multiply by full scale, then a restoring divide
// by count*4095, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dmap_div #(
   parameter int unsigned SUM_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [SUM_W-1:0]              sum,
   input  logic [dmap_pkg::FS_W-1:0]     fs,
   input  logic [SUM_W-1:0]              den,
   output dmap_pkg::dmap_div_stat_type   stat,
   output logic [dmap_pkg::PSI_W-1:0]    quo
);
   import dmap_pkg::*;

   localparam int unsigned PROD_W = SUM_W + FS_W;
   localparam int unsigned STEP_W = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [1:0] {U_IDLE, U_LOAD, U_DIV, U_FIN} ustate_type;

   ustate_type        state_ff, state_in;
   logic [PROD_W-1:0] product_ff, product_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [PSI_W-1:0]  low_ff, low_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W:0]    trial;
   logic [SUM_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, low_ff[PSI_W-1]};
   assign diff  = trial - {1'b0, den};
   assign ge    = (trial >= {1'b0, den});

   always_comb begin
      state_in   = state_ff;
      product_in = product_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      step_in    = step_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               product_in = sum * fs;
               state_in   = U_LOAD;
            end
         end
         U_LOAD: begin
            // quotient fits PSI_W bits, so the upper part is already below den
            rem_in   = product_ff[PROD_W-1:FS_W];
            low_in   = {product_ff[FS_W-1:0], {FRAC_W{1'b0}}};
            step_in  = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            low_in  = {low_ff[PSI_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            state_in = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      product_ff <= product_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      step_ff    <= step_in;
   end

   assign stat = '{busy: (state_ff != U_IDLE), done: (state_ff == U_FIN)};
   assign quo  = low_ff;

endmodule

@@ src/dual_moving_average_pressure.sv @@
// ----------------------------------------------------------------------------
// dual_moving_average_pressure
// Two-channel moving-average filter scaled to pressure in 1/256 psi.
// ----------------------------------------------------------------------------
// req_bus carries one pair of ADC counts per transfer; rsp_bus returns one
// pair of filtered pressures per accepted pair, in order. csr_bus writes
// full_scale_psi and is always ready; write it only while the block is idle.
// Each pair is written into both windows, the valid entries are summed one
// per cycle, then one shared multiplier and a 1-bit-per-cycle divider scale
// channel A and then channel B (24 divide steps each).
// From req transfer to rsp valid the block reads count entries, where count
// is the number of valid entries (up to WINDOW_DEPTH), drains the last
// registered read, scales each channel in the scaling unit and then loads
// the output register. One pair is in flight at a time: req_bus.ready is
// low from acceptance until the result is loaded into the output register,
// so no new pair is accepted before then. A result waiting on a stalled
// receiver holds the output register; the next pair may be accepted
// meanwhile, but its result waits for the register to drain. Reset
// rewinds the write position, marks the windows empty and sets
// full_scale_psi to 5000.
// ----------------------------------------------------------------------------
module dual_moving_average_pressure #(
   parameter int unsigned WINDOW_DEPTH = dmap_pkg::DMAP_WINDOW_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   dmap_req_if.sink   req_bus,
   dmap_rsp_if.source rsp_bus,
   dmap_csr_if.sink   csr_bus
);
   import dmap_pkg::*;

   localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W = ADC_W + CNT_W;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DRAIN, ST_START_A, ST_WAIT_A, ST_START_B, ST_WAIT_B, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [FS_W-1:0]   fs_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              full_ff, full_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [PTR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [SUM_W-1:0]  sum_a_ff, sum_a_in;
   logic [SUM_W-1:0]  sum_b_ff, sum_b_in;
   logic [PSI_W-1:0]  qa_ff, qa_in;
   logic [PSI_W-1:0]  qb_ff, qb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PSI_W-1:0]  psi_a_ff, psi_a_in;
   logic [PSI_W-1:0]  psi_b_ff, psi_b_in;

   logic              req_xfer;
   logic              wrap;
   logic [PTR_W-1:0]  ptr_next;
   logic [CNT_W-1:0]  count_new;
   logic [ADC_W-1:0]  rd_a;
   logic [ADC_W-1:0]  rd_b;
   logic              div_start;
   logic [SUM_W-1:0]  div_sum;
   logic [PSI_W-1:0]  div_quo;
   dmap_div_stat_type div_stat;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign wrap      = (wr_ptr_ff == LAST_PTR);
   assign ptr_next  = wrap ? '0 : wr_ptr_ff + 1'b1;
   assign count_new = (full_ff || wrap) ? DEPTH_CNT : CNT_W'(ptr_next);

   assign div_start = ((state_ff == ST_START_A) || (state_ff == ST_START_B)) && !div_stat.busy;
   assign div_sum   = (state_ff == ST_START_B) ? sum_b_ff : sum_a_ff;

   dmap_window #(
      .DEPTH (WINDOW_DEPTH),
      .PTR_W (PTR_W)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wr_ptr_ff),
      .wr_a    (req_bus.adc_a),
      .wr_b    (req_bus.adc_b),
      .rd_addr (rd_idx_ff),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   dmap_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (div_sum),
      .fs    (fs_ff),
      .den   (den_ff),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      den_in       = den_ff;
      rd_idx_in    = rd_idx_ff;
      rd_valid_in  = 1'b0;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      psi_a_in     = psi_a_ff;
      psi_b_in     = psi_b_ff;

      if (rd_valid_ff) begin
         sum_a_in = sum_a_ff + SUM_W'(rd_a);
         sum_b_in = sum_b_ff + SUM_W'(rd_b);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               wr_ptr_in = ptr_next;
               full_in   = full_ff || wrap;
               count_in  = count_new;
               // count * 4095 as count * 4096 - count
               den_in    = {count_new, {ADC_W{1'b0}}} - SUM_W'(count_new);
               rd_idx_in = '0;
               sum_a_in  = '0;
               sum_b_in  = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            rd_valid_in = 1'b1;
            rd_idx_in   = rd_idx_ff + 1'b1;
            if (CNT_W'(rd_idx_ff) == count_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_START_A;
         end
         ST_START_A: begin
            if (div_start) begin
               state_in = ST_WAIT_A;
            end
         end
         ST_WAIT_A: begin
            if (div_stat.done) begin
               qa_in    = div_quo;
               state_in = ST_START_B;
            end
         end
         ST_START_B: begin
            if (div_start) begin
               state_in = ST_WAIT_B;
            end
         end
         ST_WAIT_B: begin
            if (div_stat.done) begin
               qb_in    = div_quo;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               psi_a_in     = qa_ff;
               psi_b_in     = qb_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fs_ff        <= FS_RESET;
         wr_ptr_ff    <= '0;
         full_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         full_ff      <= full_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            fs_ff <= csr_bus.full_scale_psi;
         end
      end
      count_ff  <= count_in;
      den_ff    <= den_in;
      rd_idx_ff <= rd_idx_in;
      sum_a_ff  <= sum_a_in;
      sum_b_ff  <= sum_b_in;
      qa_ff     <= qa_in;
      qb_ff     <= qb_in;
      psi_a_ff  <= psi_a_in;
      psi_b_ff  <= psi_b_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.psi_a = psi_a_ff;
   assign rsp_bus.psi_b = psi_b_ff;

endmodule

@@ src/dmap_checker.sv @@
// ----------------------------------------------------------------------------
// dmap_checker
// Port-level checks of the pressure filter, bound to the top level.
// ----------------------------------------------------------------------------
module dmap_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dmap_pkg::PSI_W-1:0]  psi_a,
   input logic [dmap_pkg::PSI_W-1:0]  psi_b,
   input logic                        csr_ready
);

   // one pair in flight: no second transfer right behind the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req ready right after a req transfer");

   // the windows must be summed and scaled before any new result shows
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after a req transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(psi_a) && $stable(psi_b)))
      else $error("stalled result changed or dropped");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("output not empty or input not ready after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind dual_moving_average_pressure dmap_checker u_dmap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .psi_a     (rsp_bus.psi_a),
   .psi_b     (rsp_bus.psi_b),
   .csr_ready (csr_bus.ready)
);

@@ verif/pressure_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_checker
// Watches the sample, result and register-write channels of the dual
// moving-average pressure filter. It keeps its own copy of both windows and
// of full_scale_psi, predicts the pressure pair for every accepted sample
// pair, and compares each result transfer field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module pressure_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [dmap_pkg::ADC_W-1:0] req_adc_a,
   input  logic [dmap_pkg::ADC_W-1:0] req_adc_b,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [dmap_pkg::PSI_W-1:0] rsp_psi_a,
   input  logic [dmap_pkg::PSI_W-1:0] rsp_psi_b,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [dmap_pkg::FS_W-1:0]  csr_full_scale_psi,
   output int                         error_count,
   output int                         outstanding
);
   import dmap_pkg::*;

   localparam int unsigned DEPTH       = DMAP_WINDOW_DEPTH;
   localparam longint unsigned ADC_MAX = (64'd1 << ADC_W) - 1;

   typedef struct packed {
      logic [PSI_W-1:0] psi_a;
      logic [PSI_W-1:0] psi_b;
   } psi_pair_type;

   logic [ADC_W-1:0] window_a [DEPTH];
   logic [ADC_W-1:0] window_b [DEPTH];
   int unsigned      next_pos;
   logic             wrapped;
   logic [FS_W-1:0]  full_scale;
   psi_pair_type     expected_psi [$];

   function automatic logic [PSI_W-1:0] scaled_mean(longint unsigned total,
                                                    int unsigned n,
                                                    logic [FS_W-1:0] fs);
      longint unsigned num;
      longint unsigned den;
      num = total * longint'(fs) * 256;
      den = longint'(n) * ADC_MAX;
      return PSI_W'(num / den);
   endfunction

   function automatic psi_pair_type mean_pressure();
      psi_pair_type    res;
      longint unsigned sum_a;
      longint unsigned sum_b;
      int unsigned     n;
      sum_a = 0;
      sum_b = 0;
      n = wrapped ? DEPTH : next_pos;
      for (int unsigned i = 0; i < n; i++) begin
         sum_a += window_a[i];
         sum_b += window_b[i];
      end
      res.psi_a = scaled_mean(sum_a, n, full_scale);
      res.psi_b = scaled_mean(sum_b, n, full_scale);
      return res;
   endfunction

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      psi_pair_type want;
      if (reset) begin
         next_pos   = 0;
         wrapped    = 1'b0;
         full_scale = FS_RESET;
         expected_psi.delete();
         outstanding = 0;
      end else begin
         if (csr_valid && csr_ready)
            full_scale = csr_full_scale_psi;
         if (req_valid && req_ready) begin
            window_a[next_pos] = req_adc_a;
            window_b[next_pos] = req_adc_b;
            next_pos = (next_pos + 1) % DEPTH;
            if (next_pos == 0)
               wrapped = 1'b1;
            expected_psi.push_back(mean_pressure());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_psi.size() == 0) begin
               $error("result transfer with nothing expected: psi_a %0d psi_b %0d",
                      rsp_psi_a, rsp_psi_b);
               error_count++;
            end else begin
               want = expected_psi.pop_front();
               if (rsp_psi_a !== want.psi_a) begin
                  $error("psi_a: expected %0d, actual %0d", want.psi_a, rsp_psi_a);
                  error_count++;
               end
               if (rsp_psi_b !== want.psi_b) begin
                  $error("psi_b: expected %0d, actual %0d", want.psi_b, rsp_psi_b);
                  error_count++;
               end
            end
         end
         outstanding = expected_psi.size();
      end
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the dual moving-average pressure filter. A short
// directed run covers count extremes, partial and wrapped windows and the
// full-scale corner values; random phases then vary full_scale_psi, idling
// on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
   import dmap_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 120;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 75;
   localparam logic [ADC_W-1:0] ADC_TOP = '1;
   localparam logic [FS_W-1:0]  FS_TOP  = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic send_idle = 1'b1;
   logic recv_idle = 1'b1;
   logic hold_rsp  = 1'b0;
   int   error_count;
   int   outstanding;
   int   quiet_cycles;

   dmap_req_if req_bus ();
   dmap_rsp_if rsp_bus ();
   dmap_csr_if csr_bus ();

   dual_moving_average_pressure dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pressure_checker u_pressure_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_bus.valid),
      .req_ready          (req_bus.ready),
      .req_adc_a          (req_bus.adc_a),
      .req_adc_b          (req_bus.adc_b),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_psi_a          (rsp_bus.psi_a),
      .rsp_psi_b          (rsp_bus.psi_b),
      .csr_valid          (csr_bus.valid),
      .csr_ready          (csr_bus.ready),
      .csr_full_scale_psi (csr_bus.full_scale_psi),
      .error_count        (error_count),
      .outstanding        (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [ADC_W-1:0] rand_adc();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ADC_TOP;
         default: return ADC_W'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic send_pair(input logic [ADC_W-1:0] a, input logic [ADC_W-1:0] b);
      while (send_idle && $urandom_range(0, 99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.adc_a <= a;
      req_bus.adc_b <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_full_scale(input logic [FS_W-1:0] fs);
      drain();
      csr_bus.valid          <= 1'b1;
      csr_bus.full_scale_psi <= fs;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= !(recv_idle && $urandom_range(0, 99) < 32);
         end
      end
   end

   // watchdog: cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic [FS_W-1:0] fs;
      req_bus.valid          <= 1'b0;
      req_bus.adc_a          <= '0;
      req_bus.adc_b          <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.full_scale_psi <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // growing window up to the first wrap at the reset full scale
      send_pair('0, '0);
      send_pair(ADC_TOP, ADC_TOP);
      send_pair(ADC_TOP, '0);
      send_pair('0, ADC_TOP);
      send_pair(12'hAAA, 12'h555);
      send_pair(12'h555, 12'hAAA);
      send_pair(12'd1, 12'd2048);
      send_pair(12'd2048, 12'd1);
      send_pair(ADC_TOP, ADC_TOP);

      // largest result: full window at full count, full scale at its top
      write_full_scale(FS_TOP);
      repeat (8) send_pair(ADC_TOP, ADC_TOP);

      // zero full scale gives zero pressure
      write_full_scale('0);
      send_pair(ADC_TOP, 12'd100);
      send_pair(12'd7, ADC_TOP);

      write_full_scale(16'd1);
      send_pair(ADC_TOP, ADC_TOP);
      send_pair('0, '0);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       fs = FS_TOP;
            1:       fs = '0;
            2:       fs = 16'd1;
            3:       fs = FS_RESET;
            4:       fs = 16'd4095;
            default: fs = FS_W'($urandom_range(0, 65535));
         endcase
         write_full_scale(fs);
         send_idle = (ph != 3);
         recv_idle = (ph != 3);
         if (ph == 5)
            hold_rsp = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 6 && i == PHASE_ITEMS / 2)
               drain();
            send_pair(rand_adc(), rand_adc());
         end
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
